// ----- sv/assert_macros.svh -----
// assertion macros included by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property at every rising edge, held off while reset is high
`define ASSERT_SYNC(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check a property at every rising edge, reset included
`define ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/gape_pkg.sv -----
// shared constants, types and tables of the gnss ascii position extractor
package gape_pkg;

   // fraction digits of the fixed point results (0 to 6)
   localparam int FRAC_DIGITS = 4;

   localparam int VAL_W      = 48;
   localparam int ACC_W      = 47;
   localparam int WIDE_W     = ACC_W + 4;
   localparam int POW_W      = 20;
   localparam int FRAC_CNT_W = 3;

   localparam logic [ACC_W-1:0] MAG_MAX = 47'd99999999999999;
   localparam longint ONE_FX = 10 ** FRAC_DIGITS;
   localparam logic signed [VAL_W-1:0] MINUS_ONE = VAL_W'(-ONE_FX);

   // characters of the log stream
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_B     = 8'h42;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_9     = 8'h39;

   // number being converted, handed to the scaling unit
   typedef struct packed {
      logic [ACC_W-1:0]      mag;
      logic [FRAC_CNT_W-1:0] frac_cnt;
      logic                  neg;
      logic                  nonempty;
   } conv_req_type;

   // one result transfer
   typedef struct packed {
      logic signed [VAL_W-1:0] northing;
      logic signed [VAL_W-1:0] easting;
      logic signed [VAL_W-1:0] height;
      logic                    short_frame;
   } rsp_type;

   // ten to the power k
   function automatic logic [POW_W-1:0] pow10_of(input logic [FRAC_CNT_W-1:0] k);
      logic [POW_W-1:0] p;
      unique case (k)
         3'd0:    p = 20'd1;
         3'd1:    p = 20'd10;
         3'd2:    p = 20'd100;
         3'd3:    p = 20'd1000;
         3'd4:    p = 20'd10000;
         3'd5:    p = 20'd100000;
         3'd6:    p = 20'd1000000;
         default: p = 20'd1;
      endcase
      return p;
   endfunction

   // largest magnitude that can be scaled by ten to the k without saturating
   function automatic logic [ACC_W-1:0] sat_lim_of(input logic [FRAC_CNT_W-1:0] k);
      logic [ACC_W-1:0] l;
      unique case (k)
         3'd0:    l = 47'd99999999999999;
         3'd1:    l = 47'd9999999999999;
         3'd2:    l = 47'd999999999999;
         3'd3:    l = 47'd99999999999;
         3'd4:    l = 47'd9999999999;
         3'd5:    l = 47'd999999999;
         3'd6:    l = 47'd99999999;
         default: l = 47'd99999999999999;
      endcase
      return l;
   endfunction

endpackage

// ----- sv/gape_scale.sv -----
// pads the missing fraction digits, saturates and applies the sign; an empty field gives minus one
module gape_scale
   import gape_pkg::*;
(
   input  conv_req_type            conv_req,
   output logic signed [VAL_W-1:0] value
);

   logic [FRAC_CNT_W-1:0]  pad_cnt;
   logic [ACC_W+POW_W-1:0] mag_wide;
   logic [ACC_W+POW_W-1:0] prod;
   logic [ACC_W-1:0]       mag_sc;
   logic [VAL_W-1:0]       mag_ext;

   assign pad_cnt  = FRAC_CNT_W'(FRAC_DIGITS) - conv_req.frac_cnt;
   assign mag_wide = {{POW_W{1'b0}}, conv_req.mag};

   // scaling by a fixed power of ten, each arm a constant shift-add
   always_comb begin
      unique case (pad_cnt)
         3'd0:    prod = mag_wide;
         3'd1:    prod = mag_wide * 67'd10;
         3'd2:    prod = mag_wide * 67'd100;
         3'd3:    prod = mag_wide * 67'd1000;
         3'd4:    prod = mag_wide * 67'd10000;
         3'd5:    prod = mag_wide * 67'd100000;
         3'd6:    prod = mag_wide * 67'd1000000;
         default: prod = mag_wide;
      endcase
   end

   assign mag_sc  = (conv_req.mag > sat_lim_of(pad_cnt)) ? MAG_MAX : prod[ACC_W-1:0];
   assign mag_ext = {1'b0, mag_sc};

   always_comb begin
      if (!conv_req.nonempty) begin
         value = MINUS_ONE;
      end else if (conv_req.neg) begin
         value = VAL_W'(0) - mag_ext;
      end else begin
         value = mag_ext;
      end
   end

endmodule

// ----- sv/gnss_ascii_position_extractor.sv -----
// top level: frame tracker, decimal conversion and result buffering
// a result is registered on the transfer of the LF that closes a frame, into the skid slot if one waits
// throughput: one byte per cycle when not stalled; the byte's whole update fits between the state and result regs
// a two-deep result buffer keeps bytes flowing while one result waits to be taken
// input stalls only while both result slots are full
// reset (synchronous, active high) returns to hunting for the frame start, buffers empty
`include "assert_macros.svh"

module gnss_ascii_position_extractor
   import gape_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [7:0]              req_rx_byte,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [VAL_W-1:0] rsp_northing_fx,
   output logic signed [VAL_W-1:0] rsp_easting_fx,
   output logic signed [VAL_W-1:0] rsp_height_fx,
   output logic                    rsp_short_frame
);

   typedef enum logic [1:0] {
      PH_HUNT,
      PH_HASH,
      PH_FRAME
   } phase_type;

   typedef struct packed {
      logic nonempty;
      logic neg;
      logic point;
      logic stop;
   } num_flags_type;

   // frame tracking state
   phase_type               phase_ff,     phase_in;
   logic                    last_cr_ff,   last_cr_in;
   logic                    past_semi_ff, past_semi_in;
   logic [2:0]              field_num_ff, field_num_in;
   // number being converted
   logic [ACC_W-1:0]        acc_ff,       acc_in;
   num_flags_type           flags_ff,     flags_in;
   logic [FRAC_CNT_W-1:0]   frac_cnt_ff,  frac_cnt_in;
   // values of fields 4, 5 and 6 of the current frame
   logic signed [VAL_W-1:0] held_ff [3];
   logic signed [VAL_W-1:0] held_in [3];
   logic                    seen_ff,      seen_in;
   // result register and skid slot
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff,       rsp_in;
   logic                    skid_valid_ff, skid_valid_in;
   rsp_type                 skid_ff,      skid_in;

   logic                    accept;
   logic                    out_take;
   logic                    emit;
   logic                    clear_all;
   logic                    clear_num;
   logic [7:0]              ch;

   // feed path: the current byte taken as number text
   logic                    is_digit;
   logic [3:0]              digit;
   logic [WIDE_W-1:0]       acc_wide;
   logic [WIDE_W-1:0]       times_ten;
   logic [ACC_W-1:0]        pushed;
   logic [ACC_W-1:0]        feed_acc;
   num_flags_type           feed_flags;
   logic [FRAC_CNT_W-1:0]   feed_frac_cnt;

   // finish path: the field closed by a comma or by the frame end
   conv_req_type            conv_req;
   logic signed [VAL_W-1:0] conv_value;
   logic signed [VAL_W-1:0] fin_held [3];
   logic                    fin_seen;
   logic                    field_hit;
   logic [1:0]              slot;
   rsp_type                 new_rsp;

   assign ch        = req_rx_byte;
   assign accept    = req_valid && !req_stall;
   assign out_take  = rsp_valid_ff && !rsp_stall;
   assign req_stall = skid_valid_ff;

   // one decimal digit into the accumulator, saturating
   assign is_digit  = (ch >= CH_0) && (ch <= CH_9);
   assign digit     = 4'(ch - CH_0);
   assign acc_wide  = {4'b0, acc_ff};
   assign times_ten = (acc_wide << 3) + (acc_wide << 1) + WIDE_W'(digit);
   assign pushed    = (times_ten > WIDE_W'(MAG_MAX)) ? MAG_MAX : times_ten[ACC_W-1:0];

   always_comb begin
      feed_acc          = acc_ff;
      feed_flags        = flags_ff;
      feed_frac_cnt     = frac_cnt_ff;
      feed_flags.nonempty = 1'b1;
      if (!flags_ff.stop) begin
         // a sign counts only as the first character of a field
         priority if (!flags_ff.nonempty && (ch == CH_PLUS || ch == CH_MINUS)) begin
            if (ch == CH_MINUS) begin
               feed_flags.neg = 1'b1;
            end
         end else if (is_digit) begin
            if (!flags_ff.point) begin
               feed_acc = pushed;
            end else if (frac_cnt_ff < FRAC_CNT_W'(FRAC_DIGITS)) begin
               feed_acc      = pushed;
               feed_frac_cnt = frac_cnt_ff + FRAC_CNT_W'(1);
            end
         end else if (ch == CH_DOT && !flags_ff.point) begin
            feed_flags.point = 1'b1;
         end else begin
            // any other character ends the conversion
            feed_flags.stop = 1'b1;
         end
      end
   end

   // a closing LF is itself field text, so the field is never empty then
   assign conv_req.mag      = acc_ff;
   assign conv_req.frac_cnt = frac_cnt_ff;
   assign conv_req.neg      = flags_ff.neg;
   assign conv_req.nonempty = flags_ff.nonempty || (ch == CH_LF);

   gape_scale u_scale (
      .conv_req (conv_req),
      .value    (conv_value)
   );

   // fields 4 to 6 land in slots 0 to 2
   assign field_hit = (field_num_ff >= 3'd4) && (field_num_ff <= 3'd6);
   assign slot      = field_num_ff[1:0];

   always_comb begin
      fin_held = held_ff;
      fin_seen = seen_ff;
      if (field_hit) begin
         fin_held[slot] = conv_value;
         if (field_num_ff == 3'd6) begin
            fin_seen = 1'b1;
         end
      end
   end

   assign new_rsp.northing    = fin_held[0];
   assign new_rsp.easting     = fin_held[1];
   assign new_rsp.height      = fin_held[2];
   assign new_rsp.short_frame = !fin_seen;

   // frame tracking and field bookkeeping
   always_comb begin
      phase_in     = phase_ff;
      last_cr_in   = last_cr_ff;
      past_semi_in = past_semi_ff;
      field_num_in = field_num_ff;
      acc_in       = acc_ff;
      flags_in     = flags_ff;
      frac_cnt_in  = frac_cnt_ff;
      held_in      = held_ff;
      seen_in      = seen_ff;
      emit         = 1'b0;
      clear_all    = 1'b0;
      clear_num    = 1'b0;

      if (accept) begin
         unique case (phase_ff)
            PH_HUNT: begin
               if (ch == CH_HASH) begin
                  phase_in = PH_HASH;
               end
            end
            PH_HASH: begin
               // a repeated hash keeps waiting for the B
               if (ch == CH_B) begin
                  phase_in     = PH_FRAME;
                  last_cr_in   = 1'b0;
                  past_semi_in = 1'b0;
                  clear_all    = 1'b1;
               end else if (ch != CH_HASH) begin
                  phase_in = PH_HUNT;
               end
            end
            PH_FRAME: begin
               if (ch == CH_SEMI && !past_semi_ff) begin
                  // first semicolon restarts the field count
                  past_semi_in = 1'b1;
                  clear_all    = 1'b1;
               end else if (ch == CH_COMMA) begin
                  held_in      = fin_held;
                  seen_in      = fin_seen;
                  field_num_in = (field_num_ff == 3'd7) ? field_num_ff : field_num_ff + 3'd1;
                  clear_num    = 1'b1;
               end else begin
                  acc_in      = feed_acc;
                  flags_in    = feed_flags;
                  frac_cnt_in = feed_frac_cnt;
               end
               if (ch == CH_LF && last_cr_ff) begin
                  // cr lf closes the frame and sends the result
                  emit         = 1'b1;
                  phase_in     = PH_HUNT;
                  last_cr_in   = 1'b0;
                  past_semi_in = 1'b0;
                  clear_all    = 1'b1;
               end else begin
                  last_cr_in = (ch == CH_CR);
               end
            end
            default: begin
               phase_in = PH_HUNT;
            end
         endcase
      end

      if (clear_all) begin
         field_num_in = 3'd0;
         seen_in      = 1'b0;
         for (int i = 0; i < 3; i++) begin
            held_in[i] = MINUS_ONE;
         end
         clear_num = 1'b1;
      end
      if (clear_num) begin
         acc_in      = '0;
         flags_in    = '0;
         frac_cnt_in = '0;
      end
   end

   // result register with a skid slot behind it
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         // input is stalled here, so no new result can arrive
         if (out_take) begin
            rsp_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (!rsp_valid_ff || out_take) begin
         rsp_valid_in = emit;
         if (emit) begin
            rsp_in = new_rsp;
         end
      end else if (emit) begin
         skid_in       = new_rsp;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HUNT;
         last_cr_ff    <= 1'b0;
         past_semi_ff  <= 1'b0;
         field_num_ff  <= 3'd0;
         acc_ff        <= '0;
         flags_ff      <= '0;
         frac_cnt_ff   <= '0;
         seen_ff       <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            held_ff[i] <= MINUS_ONE;
         end
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         last_cr_ff    <= last_cr_in;
         past_semi_ff  <= past_semi_in;
         field_num_ff  <= field_num_in;
         acc_ff        <= acc_in;
         flags_ff      <= flags_in;
         frac_cnt_ff   <= frac_cnt_in;
         seen_ff       <= seen_in;
         held_ff       <= held_in;
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      // payload needs no reset
      rsp_ff  <= rsp_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_northing_fx = rsp_ff.northing;
   assign rsp_easting_fx  = rsp_ff.easting;
   assign rsp_height_fx   = rsp_ff.height;
   assign rsp_short_frame = rsp_ff.short_frame;

   // skid slot only fills behind a waiting result
   `ASSERT_SYNC(a_skid_behind_rsp, clock, reset, skid_valid_ff |-> rsp_valid_ff, "skid full while result register empty")
   // a new result follows the transfer of an LF
   `ASSERT_SYNC(a_rsp_after_lf, clock, reset, $rose(rsp_valid_ff) |-> $past(accept && (ch == CH_LF)), "result without closing LF")
   // outside a frame the field bookkeeping stays cleared
   `ASSERT_SYNC(a_idle_fields_clear, clock, reset, (phase_ff != PH_FRAME) |-> ((field_num_ff == 3'd0) && !seen_ff && !flags_ff.nonempty), "field state not cleared outside a frame")
   // the fraction count never passes the number of fraction digits
   `ASSERT_ALWAYS(a_frac_cnt_range, clock, reset || (frac_cnt_ff <= FRAC_CNT_W'(FRAC_DIGITS)), "fraction count out of range")

endmodule
